// File: rtl/core/ecph_pkg.sv
// Shared types and constants for the encoder PWM capture history block.
package ecph_pkg;

   localparam int DATA_W = 16;
   localparam int CMD_W  = 8;
   localparam int DUTY_W = 8;

   localparam logic [CMD_W-1:0] CAL_CODE_RESET = 8'd127;
   localparam logic [CMD_W-1:0] CMD_STOP       = 8'd0;

   localparam logic JOINT_LOWER = 1'b0;
   localparam logic JOINT_UPPER = 1'b1;

   // History write strobes from one joint into its memory
   typedef struct packed {
      logic sum;
      logic period;
   } hist_we_type;

   // Motor bridge drive settings
   typedef struct packed {
      logic              enable;
      logic              reverse;
      logic              forward;
      logic [DUTY_W-1:0] duty;
   } drive_type;

   // Read request from the readout sequencer
   typedef struct packed {
      logic en;
      logic joint;
      logic period;
   } rd_req_type;

endpackage

// File: rtl/core/ecph_joint.sv
// Per-joint PWM edge capture: tick counter, high-time sum, fall count, write index.
module ecph_joint
   import ecph_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   parameter int SUMMED_FALLS  = 4,
   parameter int WINDOW_FALLS  = 8,
   parameter int COUNT_WIDTH   = 16,
   localparam int IDX_W = $clog2(HISTORY_DEPTH),
   localparam int FC_W  = (WINDOW_FALLS > 1) ? $clog2(WINDOW_FALLS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_en,
   input  logic                   level,
   output hist_we_type            wr_en,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [COUNT_WIDTH-1:0] wr_sum,
   output logic [COUNT_WIDTH-1:0] wr_period,
   output logic [IDX_W-1:0]       widx
);

   logic                   prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] sum_ff, sum_in;
   logic [FC_W-1:0]        fc_ff, fc_in;
   logic [IDX_W-1:0]       widx_ff, widx_in;
   logic [COUNT_WIDTH-1:0] cnt_inc, sum_add;
   logic                   rise, fall, summing, closing;

   assign cnt_inc = cnt_ff + 1'b1;
   assign sum_add = sum_ff + cnt_inc;
   assign rise    = level & ~prev_ff;
   assign fall    = ~level & prev_ff;
   assign summing = 32'(fc_ff) < SUMMED_FALLS;
   assign closing = 32'(fc_ff) == (SUMMED_FALLS - 1);

   always_comb begin
      prev_in = prev_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      fc_in   = fc_ff;
      widx_in = widx_ff;
      wr_en   = '0;
      if (tick_en) begin
         prev_in = level;
         cnt_in  = cnt_inc;
         if (rise) begin
            wr_en.period = 1'b1;
            cnt_in       = '0;
         end else if (fall) begin
            if (summing) begin
               sum_in = sum_add;
            end
            if (closing) begin
               wr_en.sum = 1'b1;
               sum_in    = '0;
               widx_in   = (widx_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : widx_ff + 1'b1;
            end
            fc_in = (fc_ff == FC_W'(WINDOW_FALLS - 1)) ? '0 : fc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         fc_ff   <= '0;
         widx_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         fc_ff   <= fc_in;
         widx_ff <= widx_in;
      end
   end

   assign wr_addr   = widx_ff;
   assign wr_sum    = sum_add;
   assign wr_period = cnt_inc;
   assign widx      = widx_ff;

endmodule

// File: rtl/core/ecph_hist_mem.sv
// History memory of one joint: sum and period halves, one read port, registered read.
module ecph_hist_mem
   import ecph_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   parameter int COUNT_WIDTH   = 16,
   localparam int IDX_W = $clog2(HISTORY_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hist_we_type            wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [COUNT_WIDTH-1:0] wr_sum,
   input  logic [COUNT_WIDTH-1:0] wr_period,
   input  logic                   rd_en,
   input  logic                   rd_period,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [COUNT_WIDTH-1:0] rd_data
);

   logic [2*COUNT_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] sum_vld_ff;
   logic [HISTORY_DEPTH-1:0] per_vld_ff;
   logic [COUNT_WIDTH-1:0]   rd_data_ff;

   // Sum in the low half, period in the high half
   always_ff @(posedge clock) begin
      if (wr_en.sum) begin
         hist_mem[wr_addr][COUNT_WIDTH-1:0] <= wr_sum;
      end
      if (wr_en.period) begin
         hist_mem[wr_addr][2*COUNT_WIDTH-1:COUNT_WIDTH] <= wr_period;
      end
   end

   // Entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= '0;
         per_vld_ff <= '0;
      end else begin
         if (wr_en.sum) begin
            sum_vld_ff[wr_addr] <= 1'b1;
         end
         if (wr_en.period) begin
            per_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_period) begin
            rd_data_ff <= per_vld_ff[rd_addr] ?
                          hist_mem[rd_addr][2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
         end else begin
            rd_data_ff <= sum_vld_ff[rd_addr] ? hist_mem[rd_addr][COUNT_WIDTH-1:0] : '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ecph_readout.sv
// Readout sequencer: walks both joint histories oldest first and holds the output beat.
module ecph_readout
   import ecph_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   localparam int IDX_W = $clog2(HISTORY_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             start_period,
   input  drive_type        start_drive,
   input  logic [IDX_W-1:0] lower_widx,
   input  logic [IDX_W-1:0] upper_widx,
   input  logic             rsp_stall,
   output rd_req_type       rd_req,
   output logic [IDX_W-1:0] rd_addr,
   output logic             busy,
   output logic             rsp_valid,
   output logic             rsp_last,
   output logic             rsp_joint,
   output drive_type        rsp_drive
);

   logic             busy_ff, busy_in;
   logic             joint_ff, joint_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             period_ff, period_in;
   drive_type        drive_ff, drive_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_joint_ff, rsp_joint_in;
   drive_type        rsp_drive_ff, rsp_drive_in;
   logic             issue, pos_end;
   logic [IDX_W-1:0] addr;

   assign issue   = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign pos_end = pos_ff == IDX_W'(HISTORY_DEPTH - 1);
   // First word of a joint starts at its write index, the oldest entry
   assign addr    = (pos_ff == '0) ? ((joint_ff == JOINT_UPPER) ? upper_widx : lower_widx)
                                   : ptr_ff;

   always_comb begin
      busy_in      = busy_ff;
      joint_in     = joint_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      period_in    = period_ff;
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_last_in  = rsp_last_ff;
      rsp_joint_in = rsp_joint_ff;
      rsp_drive_in = rsp_drive_ff;
      if (start) begin
         busy_in   = 1'b1;
         joint_in  = JOINT_LOWER;
         pos_in    = '0;
         period_in = start_period;
         drive_in  = start_drive;
      end else if (issue) begin
         ptr_in       = (addr == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : addr + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_last_in  = (joint_ff == JOINT_UPPER) & pos_end;
         rsp_joint_in = joint_ff;
         rsp_drive_in = drive_ff;
         if (pos_end) begin
            pos_in = '0;
            if (joint_ff == JOINT_UPPER) begin
               busy_in = 1'b0;
            end else begin
               joint_in = JOINT_UPPER;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         joint_ff     <= JOINT_LOWER;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         joint_ff     <= joint_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      period_ff    <= period_in;
      drive_ff     <= drive_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_joint_ff <= rsp_joint_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rd_req.en     = issue;
   assign rd_req.joint  = joint_ff;
   assign rd_req.period = period_ff;
   assign rd_addr       = addr;
   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_joint     = rsp_joint_ff;
   assign rsp_drive     = rsp_drive_ff;

endmodule

// File: rtl/core/encoder_pwm_capture_history.sv
// Top level of the two-joint encoder PWM capture block with history readout.
// Each req beat is one timer tick: it carries the PWM levels of the lower and
// upper joint encoders and, optionally, a command byte. Every tick advances a
// wrapping tick counter per joint; a rising edge stores the count as a period
// and clears it, falling edges accumulate high time over the first
// SUMMED_FALLS falls of each WINDOW_FALLS window, and the closing fall stores
// the sum and advances that joint's write index. Histories live in one
// synchronous memory per joint (sum and period halves) and read as zero until
// written. A command sets the motor drive (zero or the calibration code stops
// it, bit 7 selects reverse, duty is the byte shifted left by one) and then
// streams 2*HISTORY_DEPTH rsp beats, lower joint first, oldest entry first:
// sums, or periods after the calibration code. After a command tick, req_stall
// stays high while the sequencer issues one memory read per cycle, pausing
// while rsp_stall holds the output register. The calibration code resets to
// 127 and is written through csr_write_enable/csr_write_data.
module encoder_pwm_capture_history
   import ecph_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   parameter int SUMMED_FALLS  = 4,
   parameter int WINDOW_FALLS  = 8,
   parameter int COUNT_WIDTH   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_upper_level,
   input  logic              req_lower_level,
   input  logic              req_command_valid,
   input  logic [CMD_W-1:0]  req_command_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_data_word,
   output logic              rsp_last_word,
   output logic              rsp_drive_enable,
   output logic              rsp_drive_reverse,
   output logic              rsp_drive_forward,
   output logic [DUTY_W-1:0] rsp_duty,
   input  logic              csr_write_enable,
   input  logic [CMD_W-1:0]  csr_write_data
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   logic [CMD_W-1:0]       cal_code_ff;
   drive_type              drive_ff, drive_in;
   logic                   tick_acc, cmd_start, cmd_calib;

   hist_we_type            lo_we, up_we;
   logic [IDX_W-1:0]       lo_waddr, up_waddr, lo_widx, up_widx;
   logic [COUNT_WIDTH-1:0] lo_wsum, up_wsum, lo_wper, up_wper;
   logic [COUNT_WIDTH-1:0] lo_rdata, up_rdata;

   rd_req_type             rd_req;
   logic [IDX_W-1:0]       rd_addr;
   logic                   busy, rsp_last, rsp_joint;
   drive_type              rsp_drive;
   logic [COUNT_WIDTH+DATA_W-1:0] word_ext;

   // Hold off ticks while a readout is still issuing reads
   assign req_stall = busy;
   assign tick_acc  = req_valid & ~req_stall;
   assign cmd_start = tick_acc & req_command_valid;
   assign cmd_calib = req_command_byte == cal_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_code_ff <= CAL_CODE_RESET;
      end else if (csr_write_enable) begin
         cal_code_ff <= csr_write_data;
      end
   end

   // Decode the sign-magnitude command into bridge controls
   always_comb begin
      drive_in = drive_ff;
      if (cmd_start) begin
         if ((req_command_byte == CMD_STOP) || cmd_calib) begin
            drive_in = '0;
         end else begin
            drive_in.enable  = 1'b1;
            drive_in.reverse = req_command_byte[CMD_W-1];
            drive_in.forward = ~req_command_byte[CMD_W-1];
            drive_in.duty    = {req_command_byte[DUTY_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '0;
      end else begin
         drive_ff <= drive_in;
      end
   end

   ecph_joint #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SUMMED_FALLS  (SUMMED_FALLS),
      .WINDOW_FALLS  (WINDOW_FALLS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_joint_lower (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_acc),
      .level     (req_lower_level),
      .wr_en     (lo_we),
      .wr_addr   (lo_waddr),
      .wr_sum    (lo_wsum),
      .wr_period (lo_wper),
      .widx      (lo_widx)
   );

   ecph_joint #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SUMMED_FALLS  (SUMMED_FALLS),
      .WINDOW_FALLS  (WINDOW_FALLS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_joint_upper (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_acc),
      .level     (req_upper_level),
      .wr_en     (up_we),
      .wr_addr   (up_waddr),
      .wr_sum    (up_wsum),
      .wr_period (up_wper),
      .widx      (up_widx)
   );

   ecph_hist_mem #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_mem_lower (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (lo_we),
      .wr_addr   (lo_waddr),
      .wr_sum    (lo_wsum),
      .wr_period (lo_wper),
      .rd_en     (rd_req.en & (rd_req.joint == JOINT_LOWER)),
      .rd_period (rd_req.period),
      .rd_addr   (rd_addr),
      .rd_data   (lo_rdata)
   );

   ecph_hist_mem #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_mem_upper (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (up_we),
      .wr_addr   (up_waddr),
      .wr_sum    (up_wsum),
      .wr_period (up_wper),
      .rd_en     (rd_req.en & (rd_req.joint == JOINT_UPPER)),
      .rd_period (rd_req.period),
      .rd_addr   (rd_addr),
      .rd_data   (up_rdata)
   );

   // Reads start once busy is registered after the command tick, so its edge writes are seen
   ecph_readout #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_readout (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd_start),
      .start_period (cmd_calib),
      .start_drive  (drive_in),
      .lower_widx   (lo_widx),
      .upper_widx   (up_widx),
      .rsp_stall    (rsp_stall),
      .rd_req       (rd_req),
      .rd_addr      (rd_addr),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_last     (rsp_last),
      .rsp_joint    (rsp_joint),
      .rsp_drive    (rsp_drive)
   );

   // Pick the joint's read register and fit the count to the word width
   assign word_ext          = {DATA_W'(0), (rsp_joint == JOINT_UPPER) ? up_rdata : lo_rdata};
   assign rsp_data_word     = word_ext[DATA_W-1:0];
   assign rsp_last_word     = rsp_last;
   assign rsp_drive_enable  = rsp_drive.enable;
   assign rsp_drive_reverse = rsp_drive.reverse;
   assign rsp_drive_forward = rsp_drive.forward;
   assign rsp_duty          = rsp_drive.duty;

`ifndef SYNTHESIS
   // A command beat always opens a readout
   a_cmd_starts_readout: assert property (@(posedge clock) disable iff (reset)
      cmd_start |=> req_stall)
      else $error("command beat did not start a readout");

   // A joint never writes both history halves on one tick
   a_one_write_per_joint: assert property (@(posedge clock) disable iff (reset)
      !(lo_we.sum && lo_we.period) && !(up_we.sum && up_we.period))
      else $error("sum and period written on the same tick");

   // A stalled readout beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_word) && $stable(rsp_last_word))
      else $error("stalled readout beat changed");

   // Reads go out only while a readout is active
   a_read_while_busy: assert property (@(posedge clock) disable iff (reset)
      rd_req.en |-> busy && !tick_acc)
      else $error("history read outside a readout");
`endif

endmodule
